// ===== design/gf256_repair_packet_encoder_core_assert.svh =====
// Assertion macros for the repair packet encoder.
// Each macro expects clk_i and rst_ni in scope.
`ifndef GF256_REPAIR_PACKET_ENCODER_CORE_ASSERT_SVH
`define GF256_REPAIR_PACKET_ENCODER_CORE_ASSERT_SVH

// Same-cycle implication.
`define GFRP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define GFRP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/gfrp_pkg.sv =====
`default_nettype none
package gfrp_pkg;

  localparam int DEF_MAX_SLOTS   = 16;
  localparam int DEF_MAX_PAYLOAD = 256;

  localparam int REQ_W    = 2;
  localparam int SLOT_W   = 4;
  localparam int IDX_W    = 8;
  localparam int BYTE_W   = 8;
  localparam int RSEL_W   = 4;
  localparam int OFF_W    = 9;
  localparam int STATUS_W = 2;
  localparam int RLEN_W   = 9;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  localparam logic [REQ_W-1:0] REQ_DATA    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FETCH   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_RELEASE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_ACCEPTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_COMPLETE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_REJECTED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_REPAIR   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_GROUP_SLOTS    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPAIR_PACKETS = 1'b1;

  localparam logic [CFG_DATA_W-1:0] CFG_GROUP_SLOTS_RST    = 5'd8;
  localparam logic [CFG_DATA_W-1:0] CFG_REPAIR_PACKETS_RST = 5'd1;

  localparam logic [8:0] GF_POLY = 9'h11D;

  // Controller to datapath commands
  typedef struct packed {
    logic start;   // word accepted this cycle
    logic scan;    // issue slot read for the current count
    logic finish;  // load the result register
  } gfrp_cmd_t;

  typedef struct packed {
    logic out_busy;
  } gfrp_stat_t;

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] x;
    logic [7:0] acc;
    x   = {1'b0, a};
    acc = 8'd0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc = acc ^ x[7:0];
      x = {x[7:0], 1'b0};
      if (x[8]) x = x ^ GF_POLY;
    end
    return acc;
  endfunction

endpackage
`default_nettype wire

// ===== design/gfrp_req_if.sv =====
`default_nettype none
interface gfrp_req_if;
  import gfrp_pkg::*;
  logic                valid;
  logic                ready;
  logic [REQ_W-1:0]    req_type;
  logic [SLOT_W-1:0]   slot;
  logic [IDX_W-1:0]    byte_index;
  logic [BYTE_W-1:0]   data_byte;
  logic                end_of_packet;
  logic [RSEL_W-1:0]   repair_select;
  logic [OFF_W-1:0]    out_offset;

  modport source (output valid, req_type, slot, byte_index, data_byte, end_of_packet,
                  repair_select, out_offset, input ready);
  modport sink (input valid, req_type, slot, byte_index, data_byte, end_of_packet,
                repair_select, out_offset, output ready);
endinterface
`default_nettype wire

// ===== design/gfrp_rsp_if.sv =====
`default_nettype none
interface gfrp_rsp_if;
  import gfrp_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [BYTE_W-1:0]   out_byte;
  logic                group_ready;
  logic [RLEN_W-1:0]   repair_length;

  modport source (output valid, status, out_byte, group_ready, repair_length, input ready);
  modport sink (input valid, status, out_byte, group_ready, repair_length, output ready);
endinterface
`default_nettype wire

// ===== design/gf256_repair_packet_encoder_core.sv =====
// GF(2^8) repair packet encoder. Data words load one payload byte each into a
// slot store (one RAM of MaxSlots*MaxPayload bytes, no clearing after reset);
// fetch words return one byte of a repair packet: a big-endian length table
// of two bytes per slot, then the XOR over slots of (repair+1)^slot times the
// slot byte in GF(2^8) with polynomial 0x11D. Every word, of any kind, goes
// from acceptance to a loaded result through the same steps: a sweep over
// all slots, one RAM read and one GF multiply per cycle, which also finds
// the longest payload, then a drain step and a load step. The next word is
// taken in the cycle after the load, so a new word is only accepted once the
// last one is loaded; a result still waiting in the output register holds
// back the load cycle of the following word.
// Configuration: cfg_idx_i 0 writes group_slots, 1 writes repair_packets;
// write only while no word is in flight.
`default_nettype none
`include "gf256_repair_packet_encoder_core_assert.svh"
module gf256_repair_packet_encoder_core #(
  parameter int MaxSlots   = gfrp_pkg::DEF_MAX_SLOTS,
  parameter int MaxPayload = gfrp_pkg::DEF_MAX_PAYLOAD
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  gfrp_req_if.sink                              req_i,
  gfrp_rsp_if.source                            rsp_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [gfrp_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [gfrp_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import gfrp_pkg::*;

  localparam int CntW = $clog2(MaxSlots + 1);

  gfrp_cmd_t       cmd;
  gfrp_stat_t      stat;
  logic [CntW-1:0] cnt;
  logic            in_ready;

  assign req_i.ready = in_ready;

  gfrp_ctrl #(.MaxSlots(MaxSlots)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .cnt_o      (cnt)
  );

  gfrp_dp #(.MaxSlots(MaxSlots), .MaxPayload(MaxPayload)) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .cnt_i           (cnt),
    .stat_o          (stat),
    .req_type_i      (req_i.req_type),
    .slot_i          (req_i.slot),
    .byte_index_i    (req_i.byte_index),
    .data_byte_i     (req_i.data_byte),
    .end_of_packet_i (req_i.end_of_packet),
    .repair_select_i (req_i.repair_select),
    .out_offset_i    (req_i.out_offset),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .out_valid_o     (rsp_o.valid),
    .out_ready_i     (rsp_o.ready),
    .status_o        (rsp_o.status),
    .out_byte_o      (rsp_o.out_byte),
    .group_ready_o   (rsp_o.group_ready),
    .repair_length_o (rsp_o.repair_length)
  );

  `GFRP_ASSERT_NOW(a_repair_needs_group, rsp_o.valid && rsp_o.status == ST_REPAIR, rsp_o.group_ready, "repair byte without complete group")
  `GFRP_ASSERT_NOW(a_len_zero_when_open, rsp_o.valid && !rsp_o.group_ready, rsp_o.repair_length == '0, "repair length set while group open")
  `GFRP_ASSERT_NEXT(a_busy_after_accept, req_i.valid && in_ready, !in_ready && cnt == '0, "scan did not start after accept")
  `GFRP_ASSERT_NOW(a_one_cmd, 1'b1, $onehot0({cmd.start, cmd.scan, cmd.finish}), "overlapping controller commands")
endmodule
`default_nettype wire

// ===== design/gfrp_ram.sv =====
`default_nettype none
module gfrp_ram #(
  parameter int Width = 8,
  parameter int Depth = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

// ===== design/gfrp_ctrl.sv =====
`default_nettype none
module gfrp_ctrl #(
  parameter int MaxSlots = 16,
  localparam int CntW = $clog2(MaxSlots + 1)
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire gfrp_pkg::gfrp_stat_t stat_i,
  output      gfrp_pkg::gfrp_cmd_t  cmd_o,
  output      logic [CntW-1:0]    cnt_o
);
  import gfrp_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign in_ready_o = (state_q == S_IDLE);
  assign cnt_o      = cnt_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          cnt_d       = '0;
          state_d     = S_SCAN;
        end
      end
      S_SCAN: begin
        // last count only drains the read pipeline
        if (cnt_q == CntW'(MaxSlots)) begin
          state_d = S_FIN;
        end else begin
          cmd_o.scan = 1'b1;
          cnt_d      = cnt_q + CntW'(1);
        end
      end
      S_FIN: begin
        if (!stat_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end
endmodule
`default_nettype wire

// ===== design/gfrp_dp.sv =====
`default_nettype none
module gfrp_dp #(
  parameter int MaxSlots   = 16,
  parameter int MaxPayload = 256,
  localparam int CntW = $clog2(MaxSlots + 1)
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire gfrp_pkg::gfrp_cmd_t                   cmd_i,
  input  wire logic [CntW-1:0]                       cnt_i,
  output      gfrp_pkg::gfrp_stat_t                  stat_o,
  input  wire logic [gfrp_pkg::REQ_W-1:0]            req_type_i,
  input  wire logic [gfrp_pkg::SLOT_W-1:0]           slot_i,
  input  wire logic [gfrp_pkg::IDX_W-1:0]            byte_index_i,
  input  wire logic [gfrp_pkg::BYTE_W-1:0]           data_byte_i,
  input  wire logic                                  end_of_packet_i,
  input  wire logic [gfrp_pkg::RSEL_W-1:0]           repair_select_i,
  input  wire logic [gfrp_pkg::OFF_W-1:0]            out_offset_i,
  input  wire logic                                  cfg_we_i,
  input  wire logic [gfrp_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire logic [gfrp_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  output      logic                                  out_valid_o,
  input  wire logic                                  out_ready_i,
  output      logic [gfrp_pkg::STATUS_W-1:0]         status_o,
  output      logic [gfrp_pkg::BYTE_W-1:0]           out_byte_o,
  output      logic                                  group_ready_o,
  output      logic [gfrp_pkg::RLEN_W-1:0]           repair_length_o
);
  import gfrp_pkg::*;

  localparam int SIdxW = $clog2(MaxSlots);
  localparam int LenW  = $clog2(MaxPayload + 1);
  localparam int Depth = MaxSlots * MaxPayload;
  localparam int AddrW = $clog2(Depth);
  localparam int GW    = CntW;
  localparam int M1    = (OFF_W > LenW) ? OFF_W : LenW;
  localparam int CmpW  = ((M1 > GW + 1) ? M1 : GW + 1) + 1;

  // configuration
  logic [CFG_DATA_W-1:0] cfg_g_q, cfg_r_q;
  logic [GW-1:0]         g_eff, r_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_g_q <= CFG_GROUP_SLOTS_RST;
      cfg_r_q <= CFG_REPAIR_PACKETS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_GROUP_SLOTS:    cfg_g_q <= cfg_data_i;
        CFG_REPAIR_PACKETS: cfg_r_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (32'(cfg_g_q) < 2)             g_eff = GW'(2);
    else if (32'(cfg_g_q) > MaxSlots) g_eff = GW'(MaxSlots);
    else                              g_eff = GW'(cfg_g_q);
    if (cfg_r_q == '0)                    r_eff = GW'(1);
    else if (32'(cfg_r_q) > 32'(g_eff))   r_eff = g_eff;
    else                                  r_eff = GW'(cfg_r_q);
  end

  // group state
  logic [MaxSlots-1:0] filled_q;
  logic [GW-1:0]       fcnt_q;
  logic                complete_q;
  logic [LenW-1:0]     len_q [MaxSlots];

  // item being worked on
  logic [REQ_W-1:0]    req_q;
  logic [RSEL_W-1:0]   rsel_q;
  logic [OFF_W-1:0]    off_q;
  logic [STATUS_W-1:0] st_q;

  logic [SIdxW-1:0] in_slot;
  logic             data_ok;
  logic [GW-1:0]    fcnt_inc;
  logic             ram_we;
  logic [AddrW-1:0] waddr, raddr;
  logic [7:0]       rdata;

  assign in_slot  = SIdxW'(slot_i);
  assign data_ok  = !complete_q && (32'(slot_i) < 32'(g_eff)) &&
                    (32'(byte_index_i) < MaxPayload);
  assign fcnt_inc = fcnt_q + GW'(1);
  assign ram_we   = cmd_i.start && (req_type_i == REQ_DATA) && data_ok;
  assign waddr    = AddrW'(32'(in_slot) * MaxPayload + 32'(byte_index_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filled_q   <= '0;
      fcnt_q     <= '0;
      complete_q <= 1'b0;
    end else if (cmd_i.start) begin
      if (req_type_i == REQ_DATA && data_ok && end_of_packet_i) begin
        if (!filled_q[in_slot]) begin
          filled_q[in_slot] <= 1'b1;
          fcnt_q            <= fcnt_inc;
          if (fcnt_inc >= g_eff) complete_q <= 1'b1;
        end else if (fcnt_q >= g_eff) begin
          complete_q <= 1'b1;
        end
      end else if (req_type_i == REQ_RELEASE) begin
        filled_q   <= '0;
        fcnt_q     <= '0;
        complete_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      req_q  <= req_type_i;
      rsel_q <= repair_select_i;
      off_q  <= out_offset_i;
      if (req_type_i == REQ_DATA && data_ok && end_of_packet_i)
        len_q[in_slot] <= LenW'(32'(byte_index_i) + 1);
      priority if (req_type_i == REQ_DATA && data_ok) begin
        if (end_of_packet_i && ((!filled_q[in_slot] && fcnt_inc >= g_eff) ||
                                (filled_q[in_slot] && fcnt_q >= g_eff)))
          st_q <= ST_COMPLETE;
        else
          st_q <= ST_ACCEPTED;
      end else if (req_type_i == REQ_RELEASE) begin
        st_q <= ST_ACCEPTED;
      end else begin
        st_q <= ST_REJECTED;
      end
    end
  end

  gfrp_ram #(.Width(8), .Depth(Depth)) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (data_byte_i),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // slot scan: longest payload, header length, GF accumulate
  logic [SIdxW-1:0] s_idx;
  logic             s_fill;
  logic [LenW-1:0]  s_len;
  logic [CmpW-1:0]  two_g, j_pos;
  logic             s_en;
  logic [7:0]       base;

  logic [LenW-1:0]  longest_q, hdr_q;
  logic [7:0]       coef_q, stg_coef_q, acc_q;
  logic             stg_en_q;

  assign s_idx  = cnt_i[SIdxW-1:0];
  assign s_len  = len_q[s_idx];
  assign s_fill = filled_q[s_idx] && (32'(cnt_i) < 32'(g_eff));
  assign two_g  = CmpW'(g_eff) << 1;
  assign j_pos  = CmpW'(off_q) - two_g;
  assign s_en   = s_fill && (j_pos < CmpW'(s_len));
  assign base   = 8'(rsel_q) + 8'd1;
  assign raddr  = AddrW'(32'(s_idx) * MaxPayload + 32'(j_pos[M1-1:0]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) stg_en_q <= 1'b0;
    else         stg_en_q <= cmd_i.scan && s_en;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      longest_q <= '0;
      hdr_q     <= '0;
      coef_q    <= 8'd1;
      acc_q     <= 8'd0;
    end else begin
      if (cmd_i.scan) begin
        if (s_fill && s_len > longest_q) longest_q <= s_len;
        if (CmpW'(cnt_i) == CmpW'(off_q >> 1) && filled_q[s_idx]) hdr_q <= s_len;
        coef_q <= gf_mul(coef_q, base);
      end
      if (stg_en_q) acc_q <= acc_q ^ gf_mul(stg_coef_q, rdata);
    end
    stg_coef_q <= coef_q;
  end

  // result register
  logic [CmpW-1:0]  total;
  logic [15:0]      hdr16;
  logic             out_valid_q;
  logic [STATUS_W-1:0] out_st_q;
  logic [7:0]       out_byte_q;
  logic             out_gr_q;
  logic [RLEN_W-1:0] out_rlen_q;

  assign total = two_g + CmpW'(longest_q);
  assign hdr16 = 16'(hdr_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd_i.finish) out_valid_q <= 1'b1;
    else if (out_ready_i)  out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_gr_q   <= complete_q;
      out_rlen_q <= complete_q ? RLEN_W'(total) : '0;
      if (req_q == REQ_FETCH) begin
        if (complete_q && 32'(rsel_q) < 32'(r_eff) && CmpW'(off_q) < total) begin
          out_st_q <= ST_REPAIR;
          if (CmpW'(off_q) < two_g) out_byte_q <= off_q[0] ? hdr16[7:0] : hdr16[15:8];
          else                      out_byte_q <= acc_q;
        end else begin
          out_st_q   <= ST_REJECTED;
          out_byte_q <= 8'd0;
        end
      end else begin
        out_st_q   <= st_q;
        out_byte_q <= 8'd0;
      end
    end
  end

  assign stat_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign status_o        = out_st_q;
  assign out_byte_o      = out_byte_q;
  assign group_ready_o   = out_gr_q;
  assign repair_length_o = out_rlen_q;
endmodule
`default_nettype wire
